>>> rtl/core/binary_heap_priority_queue_top_defines.svh
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BHPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bhpq assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define BHPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bhpq assertion failed");

`endif

>>> rtl/core/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CHILD_W  = ADDR_W + 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic [1:0]               status;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/core/bhpq_mem.sv
`default_nettype none

module bhpq_mem (
  input  logic                          clk_i,
  input  bhpq_pkg::mem_req_t            req_i,
  output logic [bhpq_pkg::DATA_W-1:0]   rdata_o
);
  import bhpq_pkg::*;

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bhpq_cmp.sv
`default_nettype none

module bhpq_cmp (
  input  logic signed [bhpq_pkg::DATA_W-1:0] a_i,
  input  logic signed [bhpq_pkg::DATA_W-1:0] b_i,
  input  logic                               max_mode_i,
  output logic                               beats_o
);
  import bhpq_pkg::*;

  // a strictly ahead of b under the current order
  assign beats_o = max_mode_i ? (a_i > b_i) : (a_i < b_i);

endmodule

`default_nettype wire

>>> rtl/core/binary_heap_priority_queue_top.sv
// channel   dir  handshake                  word
// in        in   in_valid_i / in_ready_o    in_word_i  (command, value)
// out       out  out_valid_o / out_ready_i  out_word_o (top_value, count, is_empty, status)
// cfg       in   cfg_we_i                   cfg_wdata_i (order_mode)
//
// push: the new entry climbs from the end slot, reading its parent at each level it climbs
// pop: the last entry is read back; unless the heap is then empty it moves to the root and
// descends, reading the left and, where present, the right child at each level (8 levels at
// most for 256 entries); every step waits on the single registered read port of the heap memory
// rejected pushes and pops go straight to the done state
// ready only in idle; a finished word waits in the output register while a new word is taken
// reset empties the heap at once and selects min order; no memory clearing pass
`default_nettype none

`include "binary_heap_priority_queue_top_defines.svh"

module binary_heap_priority_queue_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bhpq_pkg::in_word_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bhpq_pkg::out_word_t   out_word_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i
);
  import bhpq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UP_RD  = 9'b000000010,
    S_UP_CMP = 9'b000000100,
    S_POP_RD = 9'b000001000,
    S_POP_LD = 9'b000010000,
    S_DN_RL  = 9'b000100000,
    S_DN_RR  = 9'b001000000,
    S_DN_CR  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  status_e            status_q, status_d;
  logic               order_mode_q;
  logic               out_valid_q;
  out_word_t          out_word_q;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic [DATA_W-1:0]  best_q, best_d;
  logic               best_hit_q, best_hit_d;
  logic [DATA_W-1:0]  root_q, root_d;

  mem_req_t           mem_req;
  logic [DATA_W-1:0]  rdata;
  logic [DATA_W-1:0]  cmp_a;
  logic [DATA_W-1:0]  cmp_b;
  logic               beats;
  logic               in_acc;
  logic               out_load;
  logic               push_full;
  logic               pop_live;
  logic [ADDR_W-1:0]  parent;
  logic [CHILD_W-1:0] left, right, cnt_ext;

  bhpq_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bhpq_cmp u_cmp (
    .a_i        (cmp_a),
    .b_i        (cmp_b),
    .max_mode_i (order_mode_q),
    .beats_o    (beats)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign parent  = (pos_q - 1'b1) >> 1;
  assign left    = {1'b0, pos_q, 1'b1};
  assign right   = left + 1'b1;
  assign cnt_ext = CHILD_W'(cnt_q);

  assign cmp_a = (state_q == S_UP_CMP) ? val_q : rdata;
  always_comb begin
    case (state_q)
      S_UP_CMP: cmp_b = rdata;
      S_DN_RR:  cmp_b = val_q;
      default:  cmp_b = best_q;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    pos_d      = pos_q;
    val_d      = val_q;
    best_d     = best_q;
    best_hit_d = best_hit_q;
    root_d     = root_q;
    mem_req    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.command == CMD_PUSH) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              status_d = ST_OK;
              val_d    = in_word_i.value;
              pos_d    = cnt_q[ADDR_W-1:0];
              cnt_d    = cnt_q + 1'b1;
              state_d  = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              status_d = ST_OK;
              cnt_d    = cnt_q - 1'b1;
              state_d  = S_POP_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = val_q;
          state_d       = S_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = parent;
          state_d       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        if (beats) begin
          mem_req.wdata = rdata;
          pos_d         = parent;
          state_d       = S_UP_RD;
        end else begin
          mem_req.wdata = val_q;
          state_d       = S_DONE;
        end
      end
      S_POP_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cnt_q[ADDR_W-1:0];
        state_d       = S_POP_LD;
      end
      S_POP_LD: begin
        val_d = rdata;
        pos_d = '0;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DN_RL;
        end
      end
      S_DN_RL: begin
        if (left >= cnt_ext) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = val_q;
          state_d       = S_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = left[ADDR_W-1:0];
          state_d       = S_DN_RR;
        end
      end
      S_DN_RR: begin
        best_hit_d = beats;
        best_d     = beats ? rdata : val_q;
        if (right < cnt_ext) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = right[ADDR_W-1:0];
          state_d       = S_DN_CR;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          if (beats) begin
            mem_req.wdata = rdata;
            pos_d         = left[ADDR_W-1:0];
            state_d       = S_DN_RL;
          end else begin
            mem_req.wdata = val_q;
            state_d       = S_DONE;
          end
        end
      end
      S_DN_CR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        if (beats) begin
          mem_req.wdata = rdata;
          pos_d         = right[ADDR_W-1:0];
          state_d       = S_DN_RL;
        end else if (best_hit_q) begin
          mem_req.wdata = best_q;
          pos_d         = left[ADDR_W-1:0];
          state_d       = S_DN_RL;
        end else begin
          mem_req.wdata = val_q;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // shadow of the root entry
    if (mem_req.we && (mem_req.waddr == '0)) begin
      root_d = mem_req.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      status_q     <= ST_OK;
      best_hit_q   <= 1'b0;
      order_mode_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      status_q   <= status_d;
      best_hit_q <= best_hit_d;
      if (cfg_we_i) begin
        order_mode_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    val_q  <= val_d;
    best_q <= best_d;
    root_q <= root_d;
    if (out_load) begin
      out_word_q.top_value <= (cnt_q == '0) ? '0 : root_q;
      out_word_q.count     <= COUNT_W'(cnt_q);
      out_word_q.is_empty  <= (cnt_q == '0);
      out_word_q.status    <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign push_full = in_acc && (in_word_i.command == CMD_PUSH) && (cnt_q == CNT_W'(CAPACITY));
  assign pop_live  = in_acc && (in_word_i.command == CMD_POP) && (cnt_q != '0);

  `BHPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY))
  `BHPQ_ASSERT_NEXT(a_full_flag, push_full, status_q == ST_FULL)
  `BHPQ_ASSERT_NEXT(a_pop_dec, pop_live, cnt_q == CNT_W'($past(cnt_q) - 1'b1))
  `BHPQ_ASSERT_NOW(a_empty_match, out_valid_o, out_word_o.is_empty == (out_word_o.count == '0))

endmodule

`default_nettype wire

>>> dv/bhpq_heap_checker.sv
`timescale 1ns / 1ps

module bhpq_heap_checker
  import bhpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output int        mismatches_o,
  output int        pending_o
);

  logic signed [DATA_W-1:0] heap_q [CAPACITY];
  int unsigned              heap_cnt;
  logic                     max_order;
  out_word_t                heap_words_q [$];
  int                       mismatch_cnt;

  assign mismatches_o = mismatch_cnt;

  function automatic bit ranks_above(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
    return max_order ? (a > b) : (a < b);
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic signed [DATA_W-1:0] t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
  endfunction

  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t   r;
    int unsigned pos;
    int unsigned par;
    int unsigned best;
    int unsigned lft;
    int unsigned rgt;
    r = '0;
    r.status = ST_OK;
    if (w.command == CMD_PUSH) begin
      if (heap_cnt >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_cnt;
        heap_q[pos] = w.value;
        heap_cnt++;
        while (pos != 0) begin
          par = (pos - 1) / 2;
          if (!ranks_above(heap_q[pos], heap_q[par])) break;
          swap_slots(pos, par);
          pos = par;
        end
      end
    end else begin
      if (heap_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        heap_cnt--;
        heap_q[0] = heap_q[heap_cnt];
        pos = 0;
        while (1) begin
          best = pos;
          lft = 2 * pos + 1;
          rgt = lft + 1;
          if (lft < heap_cnt && ranks_above(heap_q[lft], heap_q[best])) best = lft;
          if (rgt < heap_cnt && ranks_above(heap_q[rgt], heap_q[best])) best = rgt;
          if (best == pos) break;
          swap_slots(pos, best);
          pos = best;
        end
      end
    end
    r.top_value = (heap_cnt != 0) ? heap_q[0] : '0;
    r.count     = COUNT_W'(heap_cnt);
    r.is_empty  = (heap_cnt == 0);
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      heap_words_q.delete();
      heap_cnt     = 0;
      max_order    = 1'b0;
      mismatch_cnt = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (heap_words_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: unexpected word top=%0d count=%0d empty=%0b status=%0d", $realtime,
                     out_word_i.top_value, out_word_i.count, out_word_i.is_empty,
                     out_word_i.status);
          end
        end else begin
          want = heap_words_q.pop_front();
          if (out_word_i !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch top %0d/%0d count %0d/%0d empty %0b/%0b status %0d/%0d",
                       $realtime, want.top_value, out_word_i.top_value, want.count,
                       out_word_i.count, want.is_empty, out_word_i.is_empty, want.status,
                       out_word_i.status);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) heap_words_q = {heap_words_q, heap_apply(in_word_i)};
      if (cfg_we_i) max_order = cfg_wdata_i;
      pending_o <= heap_words_q.size();
    end
  end

endmodule

>>> dv/tb_binary_heap_priority_queue_top.sv
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue_top;
  import bhpq_pkg::*;

  localparam int IdleLimit = 1000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  int        mismatches;
  int        pending;
  int        idle_cycles;
  bit        in_burst;
  bit        out_burst;

  binary_heap_priority_queue_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bhpq_heap_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $signed(32'($urandom_range(0, 8))) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_word(cmd_e cmd, logic signed [DATA_W-1:0] val);
    int gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_word_i.command <= cmd;
    in_word_i.value   <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_order(logic max_first);
    drain_words();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= max_first;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_mix(logic max_first, int n, int push_pct);
    cmd_e cmd;
    write_order(max_first);
    repeat (n) begin
      if ($urandom_range(0, 99) < push_pct) cmd = CMD_PUSH;
      else cmd = CMD_POP;
      send_word(cmd, pick_value());
    end
  endtask

  // out side stalls
  initial begin
    out_ready_i <= 1'b0;
    out_burst = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int gap;
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_burst = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // min order: pop on empty, extremes, ties
    write_order(1'b0);
    send_word(CMD_POP, $urandom);
    send_word(CMD_PUSH, 32'h7fff_ffff);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_PUSH, 0);
    send_word(CMD_PUSH, -1);
    send_word(CMD_PUSH, 5);
    send_word(CMD_PUSH, 5);
    send_word(CMD_PUSH, 1);
    repeat (4) send_word(CMD_POP, $urandom);

    // switch to max order with entries held
    write_order(1'b1);
    send_word(CMD_PUSH, 3);
    send_word(CMD_PUSH, 3);
    repeat (6) send_word(CMD_POP, $urandom);
    send_word(CMD_POP, $urandom);

    // fill past capacity, then drain past empty under the other order
    run_mix(1'b1, 300, 95);
    run_mix(1'b0, 320, 8);
    run_mix(1'($urandom_range(0, 1)), 100, 60);
    run_mix(1'($urandom_range(0, 1)), 100, 50);

    drain_words();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bhpq_pkg.sv
rtl/core/bhpq_mem.sv
rtl/core/bhpq_cmp.sv
rtl/core/binary_heap_priority_queue_top.sv
dv/bhpq_heap_checker.sv
dv/tb_binary_heap_priority_queue_top.sv
